@@ design/sacm_pkg.sv @@
// ----------------------------------------------------------------------------
// sacm_pkg
// Types, constants and the double-equality function shared by the memo cache.
// ----------------------------------------------------------------------------
package sacm_pkg;

  localparam int KIND_W = 1;
  localparam int SET_W  = 3;
  localparam int WORD_W = 4;
  localparam int DATA_W = 64;

  typedef logic [DATA_W-1:0] word_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOOKUP = 1'b0,
    KIND_INSERT = 1'b1
  } kind_t;

  localparam word_t QNAN_BITS = 64'h7FF8_0000_0000_0000;
  localparam word_t MAG_MASK  = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam word_t INF_BITS  = 64'h7FF0_0000_0000_0000;

  function automatic logic double_eq(input word_t a, input word_t b);
    logic nan_a;
    logic nan_b;
    logic zero_ab;
    nan_a   = (a & MAG_MASK) > INF_BITS;
    nan_b   = (b & MAG_MASK) > INF_BITS;
    zero_ab = ((a & MAG_MASK) == '0) && ((b & MAG_MASK) == '0);
    return !nan_a && !nan_b && (zero_ab || (a == b));
  endfunction

endpackage

@@ design/sacm_req_if.sv @@
// ----------------------------------------------------------------------------
// sacm_req_if
// Request channel: one key word per transfer with its set, position and kind.
// ----------------------------------------------------------------------------
interface sacm_req_if;
  import sacm_pkg::*;

  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [SET_W-1:0]    set_index;
  logic [WORD_W-1:0]   word_index;
  logic [DATA_W-1:0]   key_word;
  logic [DATA_W-1:0]   new_value;

  modport source (output valid, kind, set_index, word_index, key_word, new_value,
                  input ready);
  modport sink (input valid, kind, set_index, word_index, key_word, new_value,
                output ready);
endinterface

@@ design/sacm_rsp_if.sv @@
// ----------------------------------------------------------------------------
// sacm_rsp_if
// Response channel: hit flag and stored value of a completed lookup.
// ----------------------------------------------------------------------------
interface sacm_rsp_if;
  import sacm_pkg::*;

  logic              valid;
  logic              ready;
  logic              hit;
  logic [DATA_W-1:0] hit_value;

  modport source (output valid, hit, hit_value, input ready);
  modport sink (input valid, hit, hit_value, output ready);
endinterface

@@ design/set_assoc_exact_match_memo_cache_top.sv @@
// ----------------------------------------------------------------------------
// set_assoc_exact_match_memo_cache_top
// Set-associative exact-match memo cache with round-robin replacement.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one key word per word: kind (lookup or insert), set_index,
//   word_index, key_word and new_value. rsp returns one word (hit, hit_value)
//   for each lookup word at the last key position; inserts return nothing.
//   Words with an out-of-range set or position are taken and dropped.
// Throughput: one request word per cycle while req.ready is high. Each word
//   reads one key row holding every way of its set and position, all compared at once.
// Path: a lookup's last word is read from memory into the compare stage at the
//   edge that takes it, then compared into the result register that drives rsp.
// Reset: a clearing pass over every key row zeroes the key memory and loads
//   quiet NaN into the value memory; req.ready stays low meanwhile.
// Stall: the result register holds while rsp.ready is low; one more lookup
//   can wait in the compare stage, after which req.ready drops.
// ----------------------------------------------------------------------------
module set_assoc_exact_match_memo_cache_top #(
  parameter int WAYS      = 4,
  parameter int SETS      = 8,
  parameter int KEY_WORDS = 10
) (
  input logic       clk,
  input logic       rst,
  sacm_req_if.sink  req,
  sacm_rsp_if.source rsp
);
  import sacm_pkg::*;

  localparam int ROWS = SETS * KEY_WORDS;
  localparam int AW   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int SW   = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WW   = (WAYS > 1) ? $clog2(WAYS) : 1;

  typedef logic [WAYS-1:0][DATA_W-1:0] row_t;

  row_t key_mem [ROWS];
  row_t val_mem [SETS];

  logic [WW-1:0]   victim [SETS];
  logic [WAYS-1:0] match_flags;

  logic            clearing;
  logic [AW-1:0]   clr_cnt;

  logic            s1_valid;
  logic            s1_first;
  logic            s1_last;
  word_t           s1_key;
  row_t            key_rd;
  row_t            val_rd;

  logic            out_valid;
  logic            out_hit;
  word_t           out_value;

  logic            accept;
  logic            in_range;
  logic            is_last;
  logic            do_insert;
  logic            do_lookup;
  logic [AW-1:0]   row_addr;
  logic [SW-1:0]   set_addr;
  logic [WW-1:0]   way_sel;
  logic            stall1;
  logic            emit;
  logic [WAYS-1:0] way_eq;
  logic [WAYS-1:0] flags_cur;
  logic            hit_any;
  word_t           hit_val;

  assign in_range  = (32'(req.set_index) < SETS) && (32'(req.word_index) < KEY_WORDS);
  assign is_last   = (32'(req.word_index) == KEY_WORDS - 1);
  assign row_addr  = AW'(AW'(req.set_index) * AW'(KEY_WORDS) + AW'(req.word_index));
  assign set_addr  = SW'(req.set_index);
  assign way_sel   = victim[set_addr];

  assign emit      = s1_valid && s1_last;
  assign stall1    = emit && out_valid && !rsp.ready;
  assign req.ready = !clearing && !stall1;
  assign accept    = req.valid && req.ready;
  assign do_insert = accept && in_range && (kind_t'(req.kind) == KIND_INSERT);
  assign do_lookup = accept && in_range && (kind_t'(req.kind) == KIND_LOOKUP);

  // clearing pass
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_cnt  <= '0;
    end else if (clearing) begin
      if (clr_cnt == AW'(ROWS - 1)) begin
        clearing <= 1'b0;
      end
      clr_cnt <= clr_cnt + AW'(1);
    end
  end

  // key memory
  always_ff @(posedge clk) begin
    if (clearing) begin
      key_mem[clr_cnt] <= '0;
    end else if (do_insert) begin
      for (int w = 0; w < WAYS; w++) begin
        if (WW'(w) == way_sel) begin
          key_mem[row_addr][w] <= req.key_word;
        end
      end
    end else if (do_lookup) begin
      key_rd <= key_mem[row_addr];
    end
  end

  // value memory
  always_ff @(posedge clk) begin
    if (clearing) begin
      if ({1'b0, clr_cnt} < (AW + 1)'(SETS)) begin
        for (int w = 0; w < WAYS; w++) begin
          val_mem[SW'(clr_cnt)][w] <= QNAN_BITS;
        end
      end
    end else if (do_insert && is_last) begin
      for (int w = 0; w < WAYS; w++) begin
        if (WW'(w) == way_sel) begin
          val_mem[set_addr][w] <= req.new_value;
        end
      end
    end else if (do_lookup) begin
      val_rd <= val_mem[set_addr];
    end
  end

  // victim pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < SETS; s++) begin
        victim[s] <= '0;
      end
    end else if (do_insert && is_last) begin
      victim[set_addr] <= (32'(way_sel) == WAYS - 1) ? '0 : way_sel + WW'(1);
    end
  end

  // compare stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!stall1) begin
      s1_valid <= do_lookup;
    end
  end

  always_ff @(posedge clk) begin
    if (do_lookup) begin
      s1_first <= (req.word_index == '0);
      s1_last  <= is_last;
      s1_key   <= req.key_word;
    end
  end

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      way_eq[w] = double_eq(s1_key, key_rd[w]);
    end
    flags_cur = (s1_first ? '1 : match_flags) & way_eq;
    hit_any   = |flags_cur;
    hit_val   = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (flags_cur[w]) begin
        hit_val = val_rd[w];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      match_flags <= '1;
    end else if (s1_valid && !stall1) begin
      match_flags <= s1_last ? '1 : flags_cur;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit && !stall1) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit && !stall1) begin
      out_hit   <= hit_any;
      out_value <= hit_val;
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.hit       = out_hit;
  assign rsp.hit_value = out_value;

  a_no_accept_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !accept)
    else $error("word taken during clearing pass");

  a_flags_reset_after_result: assert property (@(posedge clk) disable iff (rst)
    (emit && !stall1) |=> (match_flags == '1))
    else $error("match flags not restored after result");

  a_stall_needs_held_result: assert property (@(posedge clk) disable iff (rst)
    stall1 |-> (rsp.valid && !rsp.ready))
    else $error("compare stage stalled without a held result");

  a_miss_value_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.hit) |-> (rsp.hit_value == '0))
    else $error("miss carries nonzero value");

endmodule
